FILE: hdl/pdrt_pkg.sv
`default_nettype none

package pdrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;

   localparam logic [15:0] ALL_ONES16 = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_CLEAR      = 2'd0,
      OP_INSERT     = 2'd1,
      OP_FIND_ID    = 2'd2,
      OP_FIND_CLASS = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_ABSENT    = 3'd3,
      ST_REJECTED  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  bus_number;
      logic [4:0]  device_number;
      logic [2:0]  function_number;
      logic [15:0] vid;
      logic [15:0] did;
      logic [23:0] class_word;
      logic [7:0]  revision;
      logic        multi_fn;
      logic [15:0] class_key;
      logic [15:0] subclass_key;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  entry_index;
      logic [7:0]  found_bus;
      logic [4:0]  found_device_number;
      logic [2:0]  found_function;
      logic [15:0] found_vendor;
      logic [15:0] found_device;
      logic [23:0] found_class;
      logic [7:0]  found_revision;
      logic        found_multi;
   } rsp_type;

   // one stored function record
   typedef struct packed {
      logic [7:0]  bus_number;
      logic [4:0]  device_number;
      logic [2:0]  function_number;
      logic [15:0] vid;
      logic [15:0] did;
      logic [23:0] class_word;
      logic [7:0]  revision;
      logic        multi_fn;
   } rec_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type     op;
      logic       early;
      status_type status;
      rec_type    rec;
   } job_type;

   function automatic logic [4:0] to_entry_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+4:0] wide;
      wide = (IDX_W + 5)'(idx);
      return wide[4:0];
   endfunction

   function automatic rsp_type zero_rsp(input status_type st);
      rsp_type r;
      r        = '0;
      r.status = st;
      return r;
   endfunction

   function automatic rsp_type rec_rsp(input logic [IDX_W-1:0] idx, input rec_type rec);
      rsp_type r;
      r.status              = ST_OK;
      r.entry_index         = to_entry_index(idx);
      r.found_bus           = rec.bus_number;
      r.found_device_number = rec.device_number;
      r.found_function      = rec.function_number;
      r.found_vendor        = rec.vid;
      r.found_device        = rec.did;
      r.found_class         = rec.class_word;
      r.found_revision      = rec.revision;
      r.found_multi         = rec.multi_fn;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/pdrt_front.sv
`default_nettype none

module pdrt_front
   import pdrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    queue_full,
   input  wire req_type req,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata,
   output logic         push,
   output job_type      job
);

   logic reject_ff;
   logic reject_in;

   assign reject_in = csr_we ? csr_wdata : reject_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff <= 1'b0;
      end else begin
         reject_ff <= reject_in;
      end
   end

   assign push = start && !queue_full;

   always_comb begin
      job                     = '0;
      job.op                  = op_type'(req.command);
      job.status              = ST_OK;
      job.rec.bus_number      = req.bus_number;
      job.rec.device_number   = req.device_number;
      job.rec.function_number = req.function_number;
      job.rec.vid             = req.vid;
      job.rec.did             = req.did;
      job.rec.class_word      = req.class_word;
      job.rec.revision        = req.revision;
      job.rec.multi_fn        = req.multi_fn;
      unique case (op_type'(req.command))
         OP_CLEAR: begin
            job.early = 1'b1;
         end
         OP_INSERT: begin
            if (req.vid == ALL_ONES16) begin
               job.early  = 1'b1;
               job.status = ST_ABSENT;
            end
         end
         OP_FIND_ID: begin
            if (reject_ff && (req.vid == ALL_ONES16 || req.did == ALL_ONES16)) begin
               job.early  = 1'b1;
               job.status = ST_REJECTED;
            end
         end
         OP_FIND_CLASS: begin
            // class key sits where base class and subclass sit in a record
            job.rec.class_word = {req.class_key[7:0], req.subclass_key[7:0], 8'h00};
            if (reject_ff && (req.class_key == ALL_ONES16 || req.subclass_key == ALL_ONES16)) begin
               job.early  = 1'b1;
               job.status = ST_REJECTED;
            end
         end
         default: begin
            job.early = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/pdrt_queue.sv
`default_nettype none

module pdrt_queue
   import pdrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         empty,
   output job_type      head
);

   job_type                 slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pdrt_back.sv
`default_nettype none

module pdrt_back
   import pdrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    queue_empty,
   input  wire job_type head,
   output logic         pop,
   output logic         rsp_strobe,
   output rsp_type      rsp
);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    issued_ff, issued_in;
   logic                    rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    mem_we;
   logic                    hit;

   rec_type                 mem_q [TABLE_DEPTH];
   rec_type                 rd_data_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      if (job_ff.op == OP_FIND_ID) begin
         hit = (rd_data_ff.vid == job_ff.rec.vid)
            && (rd_data_ff.did == job_ff.rec.did);
      end else begin
         hit = (rd_data_ff.class_word[23:8] == job_ff.rec.class_word[23:8]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      idx_in        = idx_ff;
      issued_in     = issued_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_valid_in   = rd_valid_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               job_in    = head;
               idx_in    = '0;
               issued_in = 1'b0;
               if (head.early) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = zero_rsp(head.status);
                  if (head.op == OP_CLEAR) begin
                     valid_in = '0;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (job_ff.op == OP_INSERT) begin
               // first free entry takes the record
               if (!valid_ff[idx_ff]) begin
                  mem_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  rsp_strobe_in    = 1'b1;
                  rsp_in           = rec_rsp(idx_ff, job_ff.rec);
                  state_in         = S_IDLE;
               end else if (idx_ff == LAST_IDX) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = zero_rsp(ST_FULL);
                  state_in      = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               // read one entry per cycle, compare it the cycle after
               if (rd_pend_ff && rd_valid_ff && hit) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = rec_rsp(rd_idx_ff, rd_data_ff);
                  state_in      = S_IDLE;
               end else if (rd_pend_ff && rd_idx_ff == LAST_IDX) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = zero_rsp(ST_NOT_FOUND);
                  state_in      = S_IDLE;
               end else if (!issued_ff) begin
                  rd_pend_in  = 1'b1;
                  rd_idx_in   = idx_ff;
                  rd_valid_in = valid_ff[idx_ff];
                  if (idx_ff == LAST_IDX) begin
                     issued_in = 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issued_ff     <= 1'b0;
         rd_pend_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issued_ff     <= issued_in;
         rd_pend_ff    <= rd_pend_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      job_ff      <= job_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      rd_valid_ff <= rd_valid_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[idx_ff] <= job_ff.rec;
      end
      rd_data_ff <= mem_q[idx_ff];
   end

   a_strobe_ends_job: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == S_IDLE)
      else $error("response issued while a scan is still running");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status != ST_OK) |->
      (rsp_ff.entry_index == '0 && rsp_ff.found_vendor == '0 && rsp_ff.found_class == '0))
      else $error("error response carries record data");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == S_SCAN)
      else $error("pending table read outside of a scan");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_strobe_ff || state_ff == S_SCAN))
      else $error("dequeued request neither answered nor scanned");

endmodule

`default_nettype wire

FILE: hdl/pci_device_record_table.sv
`default_nettype none

// pci function record table. a request (start high while busy is low) is
// one of clear, insert, find by vendor/device id or find by base class and
// subclass; every request gives exactly one response, shown for a single
// cycle with rsp_strobe high. the receiver cannot stall responses, so it
// must take every strobed cycle. requests are classified on entry and wait
// in a two-deep queue; busy is high only while that queue is full. clear,
// an insert of vendor 0xffff and a strictly rejected find are answered in the
// cycle after they leave the queue. insert and find walk the table one entry
// per cycle through the single port of the record memory; a find compares
// each entry after its registered memory read. csr_wdata sets the strict
// mode that rejects find keys of 0xffff; write it only while no request is
// outstanding. no clearing pass follows reset.

module pci_device_record_table
   import pdrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   // front to queue
   logic    push;
   job_type push_job;

   // queue to back
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   job_type head;

   // busy only reflects queue space
   assign busy = queue_full;

   // accept and classify requests, hold the strict mode register
   pdrt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .req        (req_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .job        (push_job)
   );

   // short queue so front and back stall independently
   pdrt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head     (head)
   );

   // table walk, record memory, valid bits and response register
   pdrt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: tb/sv/record_table_checker.sv
`timescale 1ns / 100ps

// watches both channels of the record table, keeps its own copy of the
// table and the strict flag, and compares each response with the oldest
// predicted one
module record_table_checker
   import pdrt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_payload,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_payload,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata,
   output int           mismatches,
   output int           outstanding
);

   bit      strict_keys;
   bit      slot_used [TABLE_DEPTH];
   rec_type slot_rec [TABLE_DEPTH];
   rsp_type pending_responses [$];
   rsp_type want;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic rsp_type slot_response(input int slot);
      rsp_type res;
      res                     = '0;
      res.status              = ST_OK;
      res.entry_index         = slot[4:0];
      res.found_bus           = slot_rec[slot].bus_number;
      res.found_device_number = slot_rec[slot].device_number;
      res.found_function      = slot_rec[slot].function_number;
      res.found_vendor        = slot_rec[slot].vid;
      res.found_device        = slot_rec[slot].did;
      res.found_class         = slot_rec[slot].class_word;
      res.found_revision      = slot_rec[slot].revision;
      res.found_multi         = slot_rec[slot].multi_fn;
      return res;
   endfunction

   // works out the response of one request and updates the table copy
   function automatic rsp_type predict_table_response(input req_type r);
      rsp_type res;
      int      slot;
      res  = '0;
      slot = -1;
      case (op_type'(r.command))
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            res.status = ST_OK;
         end
         OP_INSERT: begin
            if (r.vid == ALL_ONES16) begin
               res.status = ST_ABSENT;
            end else begin
               for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                  if (!slot_used[i]) slot = i;
               if (slot < 0) begin
                  res.status = ST_FULL;
               end else begin
                  slot_used[slot]                = 1'b1;
                  slot_rec[slot].bus_number      = r.bus_number;
                  slot_rec[slot].device_number   = r.device_number;
                  slot_rec[slot].function_number = r.function_number;
                  slot_rec[slot].vid             = r.vid;
                  slot_rec[slot].did             = r.did;
                  slot_rec[slot].class_word      = r.class_word;
                  slot_rec[slot].revision        = r.revision;
                  slot_rec[slot].multi_fn        = r.multi_fn;
                  res = slot_response(slot);
               end
            end
         end
         OP_FIND_ID: begin
            if (strict_keys && (r.vid == ALL_ONES16 || r.did == ALL_ONES16)) begin
               res.status = ST_REJECTED;
            end else begin
               for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                  if (slot_used[i] && slot_rec[i].vid == r.vid
                      && slot_rec[i].did == r.did) slot = i;
               if (slot < 0) res.status = ST_NOT_FOUND;
               else res = slot_response(slot);
            end
         end
         default: begin
            if (strict_keys && (r.class_key == ALL_ONES16 || r.subclass_key == ALL_ONES16)) begin
               res.status = ST_REJECTED;
            end else begin
               for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                  if (slot_used[i] && slot_rec[i].class_word[23:16] == r.class_key[7:0]
                      && slot_rec[i].class_word[15:8] == r.subclass_key[7:0]) slot = i;
               if (slot < 0) res.status = ST_NOT_FOUND;
               else res = slot_response(slot);
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_field(input string name, input logic [23:0] exp_val,
                               input logic [23:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         strict_keys = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
         pending_responses.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: response expected none actual %0h", $time, rsp_payload);
               mismatches++;
            end else begin
               want = pending_responses.pop_front();
               report_field("status", 24'(want.status), 24'(rsp_payload.status));
               report_field("entry_index", 24'(want.entry_index),
                            24'(rsp_payload.entry_index));
               report_field("found_bus", 24'(want.found_bus), 24'(rsp_payload.found_bus));
               report_field("found_device_number", 24'(want.found_device_number),
                            24'(rsp_payload.found_device_number));
               report_field("found_function", 24'(want.found_function),
                            24'(rsp_payload.found_function));
               report_field("found_vendor", 24'(want.found_vendor),
                            24'(rsp_payload.found_vendor));
               report_field("found_device", 24'(want.found_device),
                            24'(rsp_payload.found_device));
               report_field("found_class", want.found_class, rsp_payload.found_class);
               report_field("found_revision", 24'(want.found_revision),
                            24'(rsp_payload.found_revision));
               report_field("found_multi", 24'(want.found_multi),
                            24'(rsp_payload.found_multi));
            end
         end
         if (start && !busy) pending_responses.push_back(predict_table_response(req_payload));
         if (csr_we) strict_keys = csr_wdata;
      end
      outstanding <= pending_responses.size();
   end

endmodule

FILE: tb/sv/pci_device_record_table_tb.sv
`timescale 1ns / 100ps

module pci_device_record_table_tb;
   import pdrt_pkg::*;

   localparam int RANDOM_ITEMS = 650;

   logic    clock;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   logic    csr_we      = 1'b0;
   logic    csr_wdata   = 1'b0;
   int      mismatches;
   int      outstanding;

   // no idling at all while set
   bit      steady;
   // records handed to insert since the last clear, used to aim finds
   req_type stored [$];
   int      random_count;

   pci_device_record_table DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   record_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit, several times the slowest legal run
   initial begin
      #(5_000_000);
      $display("pci_device_record_table: mismatch");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_length();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // present one request and hold it until the block takes it
   task automatic send_request(input req_type r);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic issue(input req_type r);
      int gap;
      send_request(r);
      if (op_type'(r.command) == OP_CLEAR) begin
         stored.delete();
      end else if (op_type'(r.command) == OP_INSERT && r.vid != ALL_ONES16) begin
         stored.push_back(r);
         if (stored.size() > 64) void'(stored.pop_front());
      end
      gap = gap_length();
      if (gap > 0) begin
         // lower start only when a gap follows, so it is not dropped and raised in one step
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // the request accepted at this edge shows in outstanding only after it, as outstanding is registered
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_strict(input logic value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic req_type blank_request(input op_type op);
      req_type r;
      r         = '0;
      r.command = op;
      return r;
   endfunction

   // every field random, command set by the caller
   function automatic req_type noise_request(input op_type op);
      req_type r;
      r.command         = op;
      r.bus_number      = 8'($urandom);
      r.device_number   = 5'($urandom);
      r.function_number = 3'($urandom);
      r.vid             = 16'($urandom);
      r.did             = 16'($urandom);
      r.class_word      = 24'($urandom);
      r.revision        = 8'($urandom);
      r.multi_fn        = 1'($urandom);
      r.class_key       = 16'($urandom);
      r.subclass_key    = 16'($urandom);
      return r;
   endfunction

   function automatic logic [15:0] common_id();
      logic [15:0] ids [5] = '{16'h8086, 16'h10EC, 16'h1AF4, 16'h0000, 16'hFFFE};
      return ids[$urandom_range(0, 4)];
   endfunction

   function automatic req_type make_insert();
      req_type r;
      int      roll;
      r    = noise_request(OP_INSERT);
      roll = $urandom_range(0, 99);
      // absent function now and then, often a small id pool for duplicates
      if (roll < 8) r.vid = ALL_ONES16;
      else if (roll < 45) r.vid = common_id();
      if ($urandom_range(0, 3) == 0) r.did = common_id();
      if ($urandom_range(0, 2) == 0) r.class_word[23:8] = {8'h02, 8'h00};
      return r;
   endfunction

   function automatic req_type make_id_find();
      req_type r;
      req_type pick;
      int      roll;
      r    = noise_request(OP_FIND_ID);
      roll = $urandom_range(0, 99);
      if (roll < 70 && stored.size() > 0) begin
         pick  = stored[$urandom_range(0, stored.size() - 1)];
         r.vid = pick.vid;
         r.did = pick.did;
      end else if (roll < 80) begin
         r.vid = ALL_ONES16;
      end else if (roll < 90) begin
         r.did = ALL_ONES16;
      end
      return r;
   endfunction

   function automatic req_type make_class_find();
      req_type r;
      req_type pick;
      int      roll;
      r    = noise_request(OP_FIND_CLASS);
      roll = $urandom_range(0, 99);
      // only the low byte of each key is compared, the high byte stays random
      if (roll < 70 && stored.size() > 0) begin
         pick                 = stored[$urandom_range(0, stored.size() - 1)];
         r.class_key[7:0]     = pick.class_word[23:16];
         r.subclass_key[7:0]  = pick.class_word[15:8];
      end else if (roll < 80) begin
         r.class_key = ALL_ONES16;
      end else if (roll < 90) begin
         r.subclass_key = ALL_ONES16;
      end
      return r;
   endfunction

   function automatic req_type make_random_request();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return noise_request(OP_CLEAR);
      if (roll < 45) return make_insert();
      if (roll < 72) return make_id_find();
      return make_class_find();
   endfunction

   initial begin
      req_type r;
      int      count;
      steady       = 1'b0;
      random_count = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_strict(1'b0);

      // directed: finds on an empty table
      issue(blank_request(OP_FIND_ID));
      issue(blank_request(OP_FIND_CLASS));
      // all-zero record, then one with every stored field at its top value but vid at 0xfffe
      issue(blank_request(OP_INSERT));
      r                 = blank_request(OP_INSERT);
      r.bus_number      = 8'hFF;
      r.device_number   = 5'h1F;
      r.function_number = 3'h7;
      r.vid             = 16'hFFFE;
      r.did             = 16'hFFFF;
      r.class_word      = 24'hFFFFFF;
      r.revision        = 8'hFF;
      r.multi_fn        = 1'b1;
      issue(r);
      // absent function is not stored
      r.vid = ALL_ONES16;
      issue(r);
      // duplicate of the zero record lands in the next free entry
      issue(blank_request(OP_INSERT));
      issue(blank_request(OP_FIND_ID));
      r     = blank_request(OP_FIND_ID);
      r.vid = 16'hFFFE;
      r.did = 16'hFFFF;
      issue(r);
      issue(blank_request(OP_FIND_CLASS));
      // high key bytes are ignored
      r              = blank_request(OP_FIND_CLASS);
      r.class_key    = 16'hAAFF;
      r.subclass_key = 16'h55FF;
      issue(r);
      // all-ones keys only miss while strict mode is off
      r     = blank_request(OP_FIND_ID);
      r.vid = ALL_ONES16;
      issue(r);
      r.vid = 16'h0000;
      r.did = ALL_ONES16;
      issue(r);
      r           = blank_request(OP_FIND_CLASS);
      r.class_key = ALL_ONES16;
      issue(r);
      issue(blank_request(OP_CLEAR));
      issue(blank_request(OP_FIND_ID));

      // directed: strict mode
      wait_idle();
      write_strict(1'b1);
      r            = blank_request(OP_INSERT);
      r.vid        = 16'h1234;
      r.did        = ALL_ONES16;
      r.class_word = 24'hFF0C03;
      issue(r);
      r     = blank_request(OP_FIND_ID);
      r.vid = ALL_ONES16;
      issue(r);
      r.vid = 16'h1234;
      r.did = ALL_ONES16;
      issue(r);
      r           = blank_request(OP_FIND_CLASS);
      r.class_key = ALL_ONES16;
      issue(r);
      r.class_key    = 16'h00FF;
      r.subclass_key = ALL_ONES16;
      issue(r);
      // low bytes all ones but the whole key is not, so it is searched
      r.subclass_key = 16'h000C;
      issue(r);

      // random phases, each under its own strict setting
      while (random_count < RANDOM_ITEMS) begin
         wait_idle();
         write_strict(1'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            // fill phase: run the table past full, then search it
            issue(noise_request(OP_CLEAR));
            count = $urandom_range(33, 40);
            repeat (count) issue(make_insert());
            repeat (12) issue($urandom_range(0, 1) ? make_id_find() : make_class_find());
            random_count += count + 13;
         end else begin
            count = $urandom_range(30, 70);
            repeat (count) issue(make_random_request());
            random_count += count;
         end
      end

      // drain, then leave room for any stray response
      wait_idle();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("pci_device_record_table: match");
      end else begin
         $display("pci_device_record_table: mismatch");
      end
      $finish;
   end

endmodule
